/* hdl/matrix_row_column_sorter_defines.svh */
// ============================================================================
// matrix_row_column_sorter_defines.svh
// Assertion macros used by the sorter top module.
// ============================================================================
`ifndef MATRIX_ROW_COLUMN_SORTER_DEFINES_SVH
`define MATRIX_ROW_COLUMN_SORTER_DEFINES_SVH

// clocked check, muted while reset is high
`define MRCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check that also holds through reset
`define MRCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* hdl/mrcs_pkg.sv */
// ============================================================================
// mrcs_pkg
// Shared widths, types and defaults of the matrix row/column sorter.
// ============================================================================
package mrcs_pkg;

   localparam int DATA_W   = 32;
   localparam int DEF_ROWS = 4;
   localparam int DEF_COLS = 4;

   // configuration register indexes
   localparam logic CSR_SORT_DIRECTION = 1'b0;
   localparam logic CSR_SORT_AXIS      = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic sort;     // one odd-even transposition phase this cycle
      logic shift;    // rotate the whole matrix one place in row-major order
      logic parity;   // phase parity: pairs start at positions of this parity
      logic axis;     // 0 pair along rows, 1 pair along columns
      logic descend;  // 1 descending order
   } cell_ctrl_type;

endpackage

/* hdl/mrcs_ifs.sv */
// ============================================================================
// mrcs_ifs
// Valid/ready channels of the sorter: element input and sorted output.
// ============================================================================
interface mrcs_req_if;
   logic                 valid;
   logic                 ready;
   mrcs_pkg::data_type   element_value;
   logic                 last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface mrcs_rsp_if;
   logic                 valid;
   logic                 ready;
   mrcs_pkg::data_type   sorted_value;
   logic                 last_of_matrix;

   modport source (output valid, output sorted_value, output last_of_matrix, input ready);
   modport sink   (input valid, input sorted_value, input last_of_matrix, output ready);
endinterface

/* hdl/mrcs_cell.sv */
// ============================================================================
// mrcs_cell
// One matrix element: load, compare-exchange with a line neighbor, rotate.
// ============================================================================
module mrcs_cell #(
   parameter int ROWS    = mrcs_pkg::DEF_ROWS,
   parameter int COLS    = mrcs_pkg::DEF_COLS,
   parameter int POS_ROW = 0,
   parameter int POS_COL = 0
) (
   input  logic                    clock,
   input  mrcs_pkg::cell_ctrl_type ctrl,
   input  logic                    wr_sel,
   input  mrcs_pkg::data_type      wr_data,
   input  mrcs_pkg::data_type      row_prev,
   input  mrcs_pkg::data_type      row_next,
   input  mrcs_pkg::data_type      col_prev,
   input  mrcs_pkg::data_type      col_next,
   input  mrcs_pkg::data_type      chain_next,
   output mrcs_pkg::data_type      value
);

   localparam logic ROW_HAS_PREV = (POS_COL > 0);
   localparam logic ROW_HAS_NEXT = (POS_COL < COLS - 1);
   localparam logic COL_HAS_PREV = (POS_ROW > 0);
   localparam logic COL_HAS_NEXT = (POS_ROW < ROWS - 1);
   localparam logic ROW_ODD      = 1'((POS_COL % 2) != 0);
   localparam logic COL_ODD      = 1'((POS_ROW % 2) != 0);

   mrcs_pkg::data_type value_ff, value_in;
   mrcs_pkg::data_type prev_val, next_val;
   logic has_prev, has_next, pos_odd;
   logic pair_next, pair_prev, swap_next, swap_prev;

   always_comb begin
      prev_val = ctrl.axis ? col_prev     : row_prev;
      next_val = ctrl.axis ? col_next     : row_next;
      has_prev = ctrl.axis ? COL_HAS_PREV : ROW_HAS_PREV;
      has_next = ctrl.axis ? COL_HAS_NEXT : ROW_HAS_NEXT;
      pos_odd  = ctrl.axis ? COL_ODD      : ROW_ODD;

      // this cell is the lower half of a pair, or the upper half
      pair_next = has_next && (pos_odd == ctrl.parity);
      pair_prev = has_prev && (pos_odd != ctrl.parity);
      swap_next = ctrl.descend ? (value_ff < next_val) : (value_ff > next_val);
      swap_prev = ctrl.descend ? (prev_val < value_ff) : (prev_val > value_ff);

      value_in = value_ff;
      if (wr_sel) begin
         value_in = wr_data;
      end else if (ctrl.shift) begin
         value_in = chain_next;
      end else if (ctrl.sort) begin
         if (pair_next && swap_next) begin
            value_in = next_val;
         end else if (pair_prev && swap_prev) begin
            value_in = prev_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/matrix_row_column_sorter.sv */
// ============================================================================
// matrix_row_column_sorter
// Loads a ROWS x COLS matrix, sorts every row or every column, emits it.
// ============================================================================
//  channel  dir  handshake    payload
//  req      in   valid/ready  element_value[31:0] signed, last_element
//  rsp      out  valid/ready  sorted_value[31:0] signed, last_of_matrix
//  csr      in   csr_we       csr_index (0 direction, 1 axis), csr_wdata
//
//  Load takes one item per cycle until last_element or a full store.
//  Sort then runs COLS phases (row axis) or ROWS phases (column axis): one
//  odd-even transposition phase per cycle across the cell grid.
//  Emission gives ROWS*COLS items from cell 0, one per accepted cycle, while
//  the cell chain rotates; a stalled rsp holds the grid. req is not ready
//  during sort and emission. Reset clears control only; cell data is kept.
// ============================================================================
`include "matrix_row_column_sorter_defines.svh"

module matrix_row_column_sorter #(
   parameter int ROWS = mrcs_pkg::DEF_ROWS,
   parameter int COLS = mrcs_pkg::DEF_COLS
) (
   input  logic       clock,
   input  logic       reset,
   mrcs_req_if.sink   req,
   mrcs_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   localparam int CELLS    = ROWS * COLS;
   localparam int IDX_W    = $clog2(CELLS);
   localparam int LINE_MAX = (ROWS > COLS) ? ROWS : COLS;
   localparam int PH_W     = $clog2(LINE_MAX);
   localparam logic [IDX_W-1:0] POS_LAST     = IDX_W'(CELLS - 1);
   localparam logic [PH_W-1:0]  ROW_PH_LAST  = PH_W'(COLS - 1);
   localparam logic [PH_W-1:0]  COL_PH_LAST  = PH_W'(ROWS - 1);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic             direction_ff, direction_in;
   logic             axis_ff, axis_in;

   logic req_fire, rsp_fire, phase_done;
   mrcs_pkg::cell_ctrl_type ctrl;
   mrcs_pkg::data_type      cell_value [CELLS];

   assign req.ready = (state_ff == ST_LOAD);
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp.valid && rsp.ready;

   assign rsp.sorted_value   = cell_value[0];
   assign rsp.last_of_matrix = (pos_ff == POS_LAST);

   assign phase_done = (phase_ff == (axis_ff ? COL_PH_LAST : ROW_PH_LAST));

   always_comb begin
      ctrl.sort    = (state_ff == ST_SORT);
      ctrl.shift   = rsp_fire;
      ctrl.parity  = phase_ff[0];
      ctrl.axis    = axis_ff;
      ctrl.descend = direction_ff;
   end

   // configuration
   always_comb begin
      direction_in = direction_ff;
      axis_in      = axis_ff;
      if (csr_we) begin
         unique case (csr_index)
            mrcs_pkg::CSR_SORT_DIRECTION: direction_in = csr_wdata;
            mrcs_pkg::CSR_SORT_AXIS:      axis_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer; pos_ff is the load position, then the emission count
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (req.last_element || (pos_ff == POS_LAST)) begin
                  pos_in   = '0;
                  phase_in = '0;
                  state_in = ST_SORT;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_SORT: begin
            phase_in = phase_ff + 1'b1;
            if (phase_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (pos_ff == POS_LAST) begin
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         phase_ff     <= '0;
         direction_ff <= 1'b0;
         axis_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         direction_ff <= direction_in;
         axis_ff      <= axis_in;
      end
   end

   // cell grid, row-major; edge neighbors tie back to the cell itself
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar c = 0; c < COLS; c++) begin : g_col
         localparam int N  = r * COLS + c;
         localparam int RP = (c > 0)        ? N - 1    : N;
         localparam int RN = (c < COLS - 1) ? N + 1    : N;
         localparam int CP = (r > 0)        ? N - COLS : N;
         localparam int CN = (r < ROWS - 1) ? N + COLS : N;
         localparam int SN = (N + 1) % CELLS;

         logic wr_sel;
         assign wr_sel = req_fire && (pos_ff == IDX_W'(N));

         mrcs_cell #(
            .ROWS    (ROWS),
            .COLS    (COLS),
            .POS_ROW (r),
            .POS_COL (c)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .wr_sel     (wr_sel),
            .wr_data    (req.element_value),
            .row_prev   (cell_value[RP]),
            .row_next   (cell_value[RN]),
            .col_prev   (cell_value[CP]),
            .col_next   (cell_value[CN]),
            .chain_next (cell_value[SN]),
            .value      (cell_value[N])
         );
      end
   end

   `MRCS_ASSERT(a_ready_excl_valid, req.ready |-> !rsp.valid, "input open while emitting")
   `MRCS_ASSERT(a_last_reopens, (rsp.valid && rsp.ready && rsp.last_of_matrix) |=> req.ready, "load not resumed after final item")
   `MRCS_ASSERT(a_last_closes, (req.valid && req.ready && req.last_element) |=> !req.ready, "input still open after last element")
   `MRCS_ASSERT(a_sort_pos_zero, (state_ff == ST_SORT) |-> (pos_ff == '0), "position not cleared for sort")
   `MRCS_ASSERT_ALWAYS(a_reset_idle, reset |=> (req.ready && !rsp.valid), "not idle after reset")

endmodule

/* verif/matrix_row_column_sorter_tb.sv */
// ============================================================================
// matrix_row_column_sorter_tb
// Loads matrices into the sorter through the req channel, under each setting
// of sort direction and sort axis, and checks every emitted item against a
// shadow model of the store. Both channels idle and stall at random.
// ============================================================================
module matrix_row_column_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS        = mrcs_pkg::DEF_ROWS;
   localparam int COLS        = mrcs_pkg::DEF_COLS;
   localparam int CELLS       = ROWS * COLS;
   localparam int SETTLE      = 2 * (ROWS + COLS);
   localparam int QUIET_LIMIT = 2000;
   localparam int TOTAL_ITEMS = 470;

   localparam mrcs_pkg::data_type VAL_MIN = 32'sh8000_0000;
   localparam mrcs_pkg::data_type VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      bit                 descend;
      bit                 by_column;
      mrcs_pkg::data_type value;
      bit                 last;
      bit                 typed;        // expected matrix is typed_value everywhere
      mrcs_pkg::data_type typed_value;
   } stim_row_type;

   typedef struct {
      mrcs_pkg::data_type value;
      logic               last;
   } sorted_item_type;

   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // first matrix fills the store without a last flag
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b0, VAL_MIN},
      '{1'b0, 1'b0, VAL_MIN, 1'b0, 1'b1, VAL_MIN},
      // short matrices: early last, old contents stay in the store
      '{1'b0, 1'b0, VAL_MAX, 1'b1, 1'b0, 32'sd0},
      '{1'b1, 1'b1, VAL_MAX, 1'b1, 1'b0, 32'sd0},
      '{1'b1, 1'b0, -32'sd1, 1'b0, 1'b0, 32'sd0},
      '{1'b1, 1'b0,  32'sd0, 1'b1, 1'b0, 32'sd0},
      '{1'b0, 1'b1,  32'sd1, 1'b0, 1'b0, 32'sd0},
      '{1'b0, 1'b1, -32'sd2, 1'b0, 1'b0, 32'sd0},
      '{1'b0, 1'b1, VAL_MAX, 1'b0, 1'b0, 32'sd0},
      '{1'b0, 1'b1, VAL_MIN, 1'b0, 1'b0, 32'sd0},
      '{1'b0, 1'b1, 32'sh5A5A_A5A5, 1'b1, 1'b0, 32'sd0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic csr_wdata;

   mrcs_req_if req_ch ();
   mrcs_rsp_if rsp_ch ();

   matrix_row_column_sorter #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block
   mrcs_pkg::data_type shadow_matrix [CELLS];
   int unsigned        shadow_fill;
   bit                 cfg_descend;
   bit                 cfg_by_column;
   sorted_item_type    sorted_expect [$];

   int  error_count;
   int  rsp_count;
   int  items_sent;
   bit  req_calm;
   bit  rsp_calm;
   int  stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic mrcs_pkg::data_type pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         3, 4, 5: return $signed($urandom_range(0, 8)) - 32'sd4;  // dense, many ties
         default: return $urandom;
      endcase
   endfunction

   function automatic bit must_follow(mrcs_pkg::data_type a, mrcs_pkg::data_type b);
      return cfg_descend ? (a < b) : (a > b);
   endfunction

   // insertion sort over one row or column of the shadow store
   function automatic void sort_line(int first, int stride, int count);
      mrcs_pkg::data_type held;
      int                 k;
      for (int i = 1; i < count; i++) begin
         held = shadow_matrix[first + i * stride];
         k = i;
         while (k > 0 && must_follow(shadow_matrix[first + (k - 1) * stride], held)) begin
            shadow_matrix[first + k * stride] = shadow_matrix[first + (k - 1) * stride];
            k--;
         end
         shadow_matrix[first + k * stride] = held;
      end
   endfunction

   function automatic void load_element(mrcs_pkg::data_type v, logic last, bit typed,
                                        mrcs_pkg::data_type typed_v);
      sorted_item_type it;
      shadow_matrix[shadow_fill] = v;
      shadow_fill++;
      if (last || shadow_fill == CELLS) begin
         if (cfg_by_column) begin
            for (int c = 0; c < COLS; c++) sort_line(c, COLS, ROWS);
         end else begin
            for (int r = 0; r < ROWS; r++) sort_line(r * COLS, 1, COLS);
         end
         for (int n = 0; n < CELLS; n++) begin
            it.value = typed ? typed_v : shadow_matrix[n];
            it.last  = (n == CELLS - 1);
            sorted_expect.push_back(it);
         end
         shadow_fill = 0;
      end
   endfunction

   task automatic report_mismatch(string field, mrcs_pkg::data_type want,
                                  mrcs_pkg::data_type got);
      $display("[%0t] rsp item %0d: %s expected %0d, got %0d",
               $realtime, rsp_count, field, want, got);
      error_count++;
   endtask

   // held valid is lowered only when a gap follows
   task automatic send_item(mrcs_pkg::data_type v, logic last, bit typed,
                            mrcs_pkg::data_type typed_v);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.element_value <= v;
      req_ch.last_element  <= last;
      do @(posedge clock); while (!req_ch.ready);
      load_element(v, last, typed, typed_v);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sorted_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic apply_config(bit descend, bit by_column);
      csr_we    <= 1'b1;
      csr_index <= mrcs_pkg::CSR_SORT_DIRECTION;
      csr_wdata <= descend;
      @(posedge clock);
      csr_index <= mrcs_pkg::CSR_SORT_AXIS;
      csr_wdata <= by_column;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_descend   = descend;
      cfg_by_column = by_column;
   endtask

   // result side: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      sorted_item_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (sorted_expect.size() == 0) begin
            report_mismatch("unexpected sorted_value", 32'sd0, rsp_ch.sorted_value);
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_ch.sorted_value !== want.value)
               report_mismatch("sorted_value", want.value, rsp_ch.sorted_value);
            if (rsp_ch.last_of_matrix !== want.last)
               report_mismatch("last_of_matrix", mrcs_pkg::data_type'(want.last),
                               mrcs_pkg::data_type'(rsp_ch.last_of_matrix));
         end
         rsp_count++;
      end
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= pick_gap(rsp_calm);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("matrix_row_column_sorter_tb: errors");
      $finish;
   end

   initial begin : stimulus
      bit [1:0] combo;
      int       kind;
      int       len;
      int       k;
      bit       flag;
      error_count   = 0;
      rsp_count     = 0;
      items_sent    = 0;
      shadow_fill   = 0;
      cfg_descend   = 1'b0;
      cfg_by_column = 1'b0;
      req_calm      = 1'b0;
      rsp_calm      = 1'b0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.element_value <= '0;
      req_ch.last_element  <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= mrcs_pkg::CSR_SORT_DIRECTION;
      csr_wdata            <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; config changes only between matrices
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (shadow_fill == 0 && (i == 0 || DIRECTED[i].descend != cfg_descend ||
                                  DIRECTED[i].by_column != cfg_by_column)) begin
            wait_idle();
            apply_config(DIRECTED[i].descend, DIRECTED[i].by_column);
         end
         send_item(DIRECTED[i].value, DIRECTED[i].last,
                   DIRECTED[i].typed, DIRECTED[i].typed_value);
      end

      // random phases: first four walk every setting, then random ones
      for (int phase = 0; items_sent < TOTAL_ITEMS; phase++) begin
         combo = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
         wait_idle();
         apply_config(combo[1], combo[0]);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         for (int m = $urandom_range(3, 6); m > 0 && items_sent < TOTAL_ITEMS; m--) begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(1, CELLS - 1);
            k    = 0;
            do begin
               if (kind < 12)      flag = (k == CELLS - 1);       // full, flagged
               else if (kind < 15) flag = 1'b0;                    // full, no flag
               else if (kind < 18) flag = (k == len - 1);          // early last
               else                flag = ($urandom_range(0, 7) == 0);
               send_item(pick_value(), flag, 1'b0, '0);
               k++;
            end while (shadow_fill != 0);
         end
      end

      req_ch.valid <= 1'b0;
      while (sorted_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("matrix_row_column_sorter_tb: clean");
      else
         $display("matrix_row_column_sorter_tb: errors");
      $finish;
   end

endmodule

/* matrix_row_column_sorter.f */
+incdir+hdl
hdl/mrcs_pkg.sv
hdl/mrcs_ifs.sv
hdl/mrcs_cell.sv
hdl/matrix_row_column_sorter.sv
verif/matrix_row_column_sorter_tb.sv
